// File: rtl/ffca_pkg.sv
// Package for the first-fit coalescing allocator.
// Holds table sizes, status codes, controller states and the command/flag structs.
// No dependencies.
package ffca_pkg;

  localparam int SEG_DEPTH      = 64;
  localparam int REC_DEPTH      = 64;
  localparam int ADDR_W         = 32;
  localparam int HEADER_BYTES   = 24;
  localparam int MIN_FREE_BYTES = 16;
  localparam int MIN_ALIGN_LOG2 = 3;
  localparam int ALIGN_W        = 5;
  localparam int STATUS_W       = 3;
  localparam int CFG_IW         = 2;

  localparam int SEG_AW = $clog2(SEG_DEPTH);
  localparam int REC_AW = $clog2(REC_DEPTH);
  localparam int CNT_W  = SEG_AW + 1;
  localparam int IDX_W  = ((SEG_AW > REC_AW) ? SEG_AW : REC_AW) + 1;
  localparam int WIDE_W = ADDR_W + 3;

  localparam logic [CFG_IW-1:0] REG_HEAP_START = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] REG_HEAP_SIZE  = CFG_IW'(1);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK, ST_EXHAUSTED, ST_OOB, ST_UNKNOWN, ST_TABLE_FULL, ST_UNUSABLE
  } status_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_NEXT, OP_SEG_RD, OP_SEG_RD_NEXT, OP_SEG_RD_PREV,
    OP_CALC, OP_TAKE_TAIL, OP_TAKE_ALL, OP_SD_WR, OP_CNT_DEC, OP_REC_LATCH,
    OP_CLR_IDX, OP_P_ADV, OP_P_CUR, OP_MRG_BOTH, OP_MRG_PREV, OP_MRG_NEXT,
    OP_SU_INIT, OP_SU_WR, OP_INS, OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t code;
  } dp_cmd_t;

  typedef struct packed {
    logic req_free;
    logic addr_zero;
    logic heap_ok;
    logic has_slot;
    logic idx_ge_cnt;
    logic idx1_lt_cnt;
    logic idx_gt_pos;
    logic rec_end;
    logic fit_bad;
    logic fit_tail;
    logic rec_hit;
    logic oob;
    logic p_less;
    logic mprev;
    logic mnext;
    logic tbl_full;
    logic out_room;
  } dp_flags_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_A_RD, S_A_CALC, S_A_CHK, S_SD_CHK, S_SD_WR,
    S_F_RD, S_F_CMP, S_F_BND, S_P_RD, S_P_CHK, S_MERGE, S_SU_CHK, S_SU_WR,
    S_DONE
  } ctrl_state_t;

endpackage

// File: rtl/ffca_in_if.sv
// Request channel interface: valid/ready plus one request transaction.
// Depends on ffca_pkg for field widths.
interface ffca_in_if;
  logic                             valid;
  logic                             ready;
  logic                             opcode;
  logic [ffca_pkg::ADDR_W-1:0]      req_size;
  logic [ffca_pkg::ALIGN_W-1:0]     align_log2;
  logic [ffca_pkg::ADDR_W-1:0]      free_addr;

  modport source (output valid, opcode, req_size, align_log2, free_addr, input ready);
  modport sink   (input valid, opcode, req_size, align_log2, free_addr, output ready);
endinterface

// File: rtl/ffca_out_if.sv
// Result channel interface: valid/ready plus one result transaction.
// Depends on ffca_pkg for field widths.
interface ffca_out_if;
  logic                             valid;
  logic                             ready;
  logic [ffca_pkg::STATUS_W-1:0]    status;
  logic [ffca_pkg::ADDR_W-1:0]      user_addr;
  logic [ffca_pkg::ADDR_W-1:0]      used_bytes;
  logic [ffca_pkg::ADDR_W-1:0]      free_bytes;

  modport source (output valid, status, user_addr, used_bytes, free_bytes, input ready);
  modport sink   (input valid, status, user_addr, used_bytes, free_bytes, output ready);
endinterface

// File: rtl/first_fit_coalescing_allocator_top.sv
// Allocate scans the free segments, then shifts entries down when a whole segment is taken;
// free searches allocation records, scans segments, then merges or shifts entries to insert.
// One transaction at a time; the result is registered, and the next request can be taken
// once it is, while a new result waits until the previous one has been handed over.
// Reset (rst_n, synchronous, low): heap regs zero, heap unusable, no segments, no records.
// Either config write reinitializes the heap; no clearing pass is needed.
module first_fit_coalescing_allocator_top (
  input  logic                          clk,
  input  logic                          rst_n,
  ffca_in_if.sink                       in_if,
  ffca_out_if.source                    out_if,
  input  logic                          cfg_we,
  input  logic [ffca_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [ffca_pkg::ADDR_W-1:0]   cfg_wdata
);
  import ffca_pkg::*;

  dp_cmd_t   cmd;
  dp_flags_t flags;

  // controller: walks the tables and chooses split, merge or insert
  ffca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .flags    (flags),
    .cmd      (cmd)
  );

  // datapath: tables, counters, fit and merge arithmetic, result register
  ffca_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_opcode      (in_if.opcode),
    .in_req_size    (in_if.req_size),
    .in_align_log2  (in_if.align_log2),
    .in_free_addr   (in_if.free_addr),
    .out_ready      (out_if.ready),
    .out_valid      (out_if.valid),
    .out_status     (out_if.status),
    .out_user_addr  (out_if.user_addr),
    .out_used_bytes (out_if.used_bytes),
    .out_free_bytes (out_if.free_bytes),
    .cmd            (cmd),
    .flags          (flags)
  );

endmodule

// File: rtl/ffca_ctrl.sv
// Allocator controller: sequences table scans, shifts and merges.
// Depends on ffca_pkg; drives ffca_dp through dp_cmd_t, reads dp_flags_t.
module ffca_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ffca_pkg::dp_flags_t flags,
  output ffca_pkg::dp_cmd_t   cmd
);
  import ffca_pkg::*;

  ctrl_state_t state_r, state_nxt;
  status_t     code_r, code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= ST_OK;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        state_nxt = S_DONE;
        if (!flags.req_free) begin
          if (!flags.heap_ok) code_nxt = ST_UNUSABLE;
          else if (!flags.has_slot) code_nxt = ST_TABLE_FULL;
          else state_nxt = S_A_RD;
        end else begin
          if (flags.addr_zero) code_nxt = ST_OK;
          else if (!flags.heap_ok) code_nxt = ST_UNUSABLE;
          else state_nxt = S_F_RD;
        end
      end
      S_A_RD: begin
        if (flags.idx_ge_cnt) begin
          code_nxt  = ST_EXHAUSTED;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_A_CALC;
        end
      end
      S_A_CALC: state_nxt = S_A_CHK;
      S_A_CHK: begin
        code_nxt = ST_OK;
        if (flags.fit_bad) state_nxt = S_A_RD;
        else if (flags.fit_tail) state_nxt = S_DONE;
        else state_nxt = S_SD_CHK;
      end
      S_SD_CHK: state_nxt = flags.idx1_lt_cnt ? S_SD_WR : S_DONE;
      S_SD_WR:  state_nxt = S_SD_CHK;
      S_F_RD: begin
        if (flags.rec_end) begin
          code_nxt  = ST_UNKNOWN;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_F_CMP;
        end
      end
      S_F_CMP: state_nxt = flags.rec_hit ? S_F_BND : S_F_RD;
      S_F_BND: begin
        if (flags.oob) begin
          code_nxt  = ST_OOB;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_P_RD;
        end
      end
      S_P_RD:  state_nxt = flags.idx_ge_cnt ? S_MERGE : S_P_CHK;
      S_P_CHK: state_nxt = flags.p_less ? S_P_RD : S_MERGE;
      S_MERGE: begin
        code_nxt = ST_OK;
        if (flags.mprev && flags.mnext) state_nxt = S_SD_CHK;
        else if (flags.mprev || flags.mnext) state_nxt = S_DONE;
        else if (flags.tbl_full) begin
          code_nxt  = ST_TABLE_FULL;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SU_CHK;
        end
      end
      S_SU_CHK: state_nxt = flags.idx_gt_pos ? S_SU_WR : S_DONE;
      S_SU_WR:  state_nxt = S_SU_CHK;
      S_DONE:   if (flags.out_room) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op   = OP_NONE;
    cmd.code = code_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      S_A_RD:   if (!flags.idx_ge_cnt) cmd.op = OP_SEG_RD;
      S_A_CALC: cmd.op = OP_CALC;
      S_A_CHK: begin
        if (flags.fit_bad) cmd.op = OP_NEXT;
        else if (flags.fit_tail) cmd.op = OP_TAKE_TAIL;
        else cmd.op = OP_TAKE_ALL;
      end
      S_SD_CHK: cmd.op = flags.idx1_lt_cnt ? OP_SEG_RD_NEXT : OP_CNT_DEC;
      S_SD_WR:  cmd.op = OP_SD_WR;
      S_F_CMP:  cmd.op = flags.rec_hit ? OP_REC_LATCH : OP_NEXT;
      S_F_BND:  if (!flags.oob) cmd.op = OP_CLR_IDX;
      S_P_RD:   if (!flags.idx_ge_cnt) cmd.op = OP_SEG_RD;
      S_P_CHK:  cmd.op = flags.p_less ? OP_P_ADV : OP_P_CUR;
      S_MERGE: begin
        if (flags.mprev && flags.mnext) cmd.op = OP_MRG_BOTH;
        else if (flags.mprev) cmd.op = OP_MRG_PREV;
        else if (flags.mnext) cmd.op = OP_MRG_NEXT;
        else if (!flags.tbl_full) cmd.op = OP_SU_INIT;
      end
      S_SU_CHK: cmd.op = flags.idx_gt_pos ? OP_SEG_RD_PREV : OP_INS;
      S_SU_WR:  cmd.op = OP_SU_WR;
      S_DONE:   if (flags.out_room) cmd.op = OP_FINISH;
      default:  cmd.op = OP_NONE;
    endcase
  end

endmodule

// File: rtl/ffca_dp.sv
// Allocator datapath: free-segment and allocation-record memories, counters, arithmetic.
// Depends on ffca_pkg; commanded by ffca_ctrl.
module ffca_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ffca_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [ffca_pkg::ADDR_W-1:0]         cfg_wdata,
  input  logic                                in_opcode,
  input  logic [ffca_pkg::ADDR_W-1:0]         in_req_size,
  input  logic [ffca_pkg::ALIGN_W-1:0]        in_align_log2,
  input  logic [ffca_pkg::ADDR_W-1:0]         in_free_addr,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [ffca_pkg::STATUS_W-1:0]       out_status,
  output logic [ffca_pkg::ADDR_W-1:0]         out_user_addr,
  output logic [ffca_pkg::ADDR_W-1:0]         out_used_bytes,
  output logic [ffca_pkg::ADDR_W-1:0]         out_free_bytes,
  input  ffca_pkg::dp_cmd_t                   cmd,
  output ffca_pkg::dp_flags_t                 flags
);
  import ffca_pkg::*;

  localparam int AW = ADDR_W;

  // request
  logic                req_op_r;
  logic [AW-1:0]       req_size_r, req_addr_r;
  logic [ALIGN_W-1:0]  req_alog_r;
  // heap config
  logic [AW-1:0]       heap_start_r, heap_size_r;
  logic [AW:0]         heap_end_r;
  logic                heap_ok_r;
  // counters
  logic [CNT_W-1:0]    cnt_r, pos_r;
  logic [IDX_W-1:0]    idx_r;
  logic [REC_DEPTH-1:0] valid_r;
  logic [REC_AW-1:0]   rec_r;
  logic [AW-1:0]       used_r;
  // working values
  logic [AW-1:0]       cand_bs_r;
  logic [AW:0]         cand_be_r;
  logic [WIDE_W-1:0]   cand_user_r;
  logic [AW-1:0]       blk_s_r, blk_sz_r, prev_s_r, prev_sz_r, cur_s_r, cur_sz_r;
  logic [AW-1:0]       user_res_r;
  // memories
  logic [2*AW-1:0]     seg_mem [SEG_DEPTH];
  logic [2*AW-1:0]     seg_rd_r;
  logic [3*AW-1:0]     rec_mem [REC_DEPTH];
  logic [3*AW-1:0]     rec_rd_r;
  // result register
  logic                out_valid_r;
  status_t             out_status_r;
  logic [AW-1:0]       out_user_r, out_used_r, out_free_r;

  logic [AW-1:0]       seg_rd_s, seg_rd_sz;
  logic [ALIGN_W-1:0]  alog_eff;
  logic [WIDE_W-1:0]   align_m1, calc_user, end_req, rem, size_nz;
  logic                fit;
  logic [AW-1:0]       total;
  logic [REC_AW-1:0]   slot;
  logic [AW:0]         blk_end;
  logic [IDX_W-1:0]    idx_p1, idx_m1, rd_idx;
  logic                cfg_hit;
  logic [AW-1:0]       new_start, new_size;
  logic [AW:0]         new_end;
  logic                new_ok;
  logic                seg_we;
  logic [SEG_AW-1:0]   seg_wa;
  logic [2*AW-1:0]     seg_wd;
  logic                take, release_rec;

  assign seg_rd_s  = seg_rd_r[2*AW-1:AW];
  assign seg_rd_sz = seg_rd_r[AW-1:0];
  assign idx_p1    = idx_r + IDX_W'(1);
  assign idx_m1    = idx_r - IDX_W'(1);

  // allocation fit arithmetic
  assign alog_eff  = (req_alog_r < ALIGN_W'(MIN_ALIGN_LOG2)) ? ALIGN_W'(MIN_ALIGN_LOG2)
                                                              : req_alog_r;
  assign align_m1  = (WIDE_W'(1) << alog_eff) - WIDE_W'(1);
  assign calc_user = (WIDE_W'(seg_rd_s) + WIDE_W'(HEADER_BYTES) + align_m1) & ~align_m1;
  assign size_nz   = (req_size_r == '0) ? WIDE_W'(1) : WIDE_W'(req_size_r);
  assign end_req   = cand_user_r + size_nz;
  assign fit       = end_req <= WIDE_W'(cand_be_r);
  assign rem       = WIDE_W'(cand_be_r) - end_req;
  assign total     = AW'(end_req - WIDE_W'(cand_bs_r));

  // lowest free allocation record
  always_comb begin
    slot = '0;
    for (int i = REC_DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) slot = REC_AW'(i);
    end
  end

  assign blk_end = {1'b0, blk_s_r} + {1'b0, blk_sz_r};

  always_comb begin
    flags.req_free    = req_op_r;
    flags.addr_zero   = req_addr_r == '0;
    flags.heap_ok     = heap_ok_r;
    flags.has_slot    = ~&valid_r;
    flags.idx_ge_cnt  = idx_r >= IDX_W'(cnt_r);
    flags.idx1_lt_cnt = idx_p1 < IDX_W'(cnt_r);
    flags.idx_gt_pos  = idx_r > IDX_W'(pos_r);
    flags.rec_end     = idx_r == IDX_W'(REC_DEPTH);
    flags.fit_bad     = !fit || ((rem != '0) && (rem < WIDE_W'(MIN_FREE_BYTES)));
    flags.fit_tail    = rem >= WIDE_W'(MIN_FREE_BYTES);
    flags.rec_hit     = valid_r[idx_r[REC_AW-1:0]] && (rec_rd_r[3*AW-1:2*AW] == req_addr_r);
    flags.oob         = (blk_s_r < heap_start_r) || (blk_end > heap_end_r);
    flags.p_less      = seg_rd_s < blk_s_r;
    flags.mprev       = (idx_r != '0) &&
                        (({1'b0, prev_s_r} + {1'b0, prev_sz_r}) == {1'b0, blk_s_r});
    flags.mnext       = (idx_r < IDX_W'(cnt_r)) && ({1'b0, cur_s_r} == blk_end);
    flags.tbl_full    = cnt_r == CNT_W'(SEG_DEPTH);
    flags.out_room    = !out_valid_r || out_ready;
  end

  // configuration values as they stand after this write
  assign cfg_hit   = cfg_we && ((cfg_index == REG_HEAP_START) || (cfg_index == REG_HEAP_SIZE));
  assign new_start = (cfg_index == REG_HEAP_START) ? cfg_wdata : heap_start_r;
  assign new_size  = (cfg_index == REG_HEAP_SIZE) ? cfg_wdata : heap_size_r;
  assign new_end   = {1'b0, new_start} + {1'b0, new_size};
  assign new_ok    = (new_size >= AW'(MIN_FREE_BYTES)) && (new_end <= {1'b1, {AW{1'b0}}});

  assign take        = (cmd.op == OP_TAKE_TAIL) || (cmd.op == OP_TAKE_ALL);
  assign release_rec = (cmd.op == OP_MRG_BOTH) || (cmd.op == OP_MRG_PREV) ||
                       (cmd.op == OP_MRG_NEXT) || (cmd.op == OP_INS);

  // segment table write port
  always_comb begin
    seg_we = 1'b1;
    seg_wa = idx_r[SEG_AW-1:0];
    seg_wd = seg_rd_r;
    if (cfg_hit) begin
      seg_wa = '0;
      seg_wd = {new_start, new_size};
    end else begin
      case (cmd.op)
        OP_TAKE_TAIL: seg_wd = {end_req[AW-1:0], rem[AW-1:0]};
        OP_SD_WR, OP_SU_WR: seg_wd = seg_rd_r;
        OP_MRG_BOTH: begin
          seg_wa = idx_m1[SEG_AW-1:0];
          seg_wd = {prev_s_r, prev_sz_r + blk_sz_r + cur_sz_r};
        end
        OP_MRG_PREV: begin
          seg_wa = idx_m1[SEG_AW-1:0];
          seg_wd = {prev_s_r, prev_sz_r + blk_sz_r};
        end
        OP_MRG_NEXT: seg_wd = {blk_s_r, cur_sz_r + blk_sz_r};
        OP_INS:      seg_wd = {blk_s_r, blk_sz_r};
        default:     seg_we = 1'b0;
      endcase
    end
  end

  always_comb begin
    case (cmd.op)
      OP_SEG_RD_NEXT: rd_idx = idx_p1;
      OP_SEG_RD_PREV: rd_idx = idx_m1;
      default:        rd_idx = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (seg_we) seg_mem[seg_wa] <= seg_wd;
    seg_rd_r <= seg_mem[rd_idx[SEG_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (take) rec_mem[slot] <= {cand_user_r[AW-1:0], cand_bs_r, total};
    rec_rd_r <= rec_mem[idx_r[REC_AW-1:0]];
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        req_op_r   <= in_opcode;
        req_size_r <= in_req_size;
        req_alog_r <= in_align_log2;
        req_addr_r <= in_free_addr;
        user_res_r <= '0;
      end
      OP_CALC: begin
        cand_bs_r   <= seg_rd_s;
        cand_be_r   <= {1'b0, seg_rd_s} + {1'b0, seg_rd_sz};
        cand_user_r <= calc_user;
      end
      OP_TAKE_TAIL, OP_TAKE_ALL: user_res_r <= cand_user_r[AW-1:0];
      OP_REC_LATCH: begin
        blk_s_r  <= rec_rd_r[2*AW-1:AW];
        blk_sz_r <= rec_rd_r[AW-1:0];
        rec_r    <= idx_r[REC_AW-1:0];
      end
      OP_P_ADV: begin
        prev_s_r  <= seg_rd_s;
        prev_sz_r <= seg_rd_sz;
      end
      OP_P_CUR: begin
        cur_s_r  <= seg_rd_s;
        cur_sz_r <= seg_rd_sz;
      end
      OP_FINISH: begin
        out_status_r <= cmd.code;
        out_user_r   <= user_res_r;
        out_used_r   <= used_r;
        out_free_r   <= heap_size_r - used_r;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_start_r <= '0;
      heap_size_r  <= '0;
      heap_end_r   <= '0;
      heap_ok_r    <= 1'b0;
      cnt_r        <= '0;
      pos_r        <= '0;
      idx_r        <= '0;
      valid_r      <= '0;
      used_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.op == OP_FINISH) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      if (cfg_hit) begin
        heap_start_r <= new_start;
        heap_size_r  <= new_size;
        heap_end_r   <= new_end;
        heap_ok_r    <= new_ok;
        cnt_r        <= new_ok ? CNT_W'(1) : '0;
        valid_r      <= '0;
        used_r       <= '0;
      end else begin
        if (take) begin
          valid_r[slot] <= 1'b1;
          used_r        <= used_r + total;
        end
        if (release_rec) begin
          valid_r[rec_r] <= 1'b0;
          used_r         <= used_r - blk_sz_r;
        end
        case (cmd.op)
          OP_LOAD, OP_CLR_IDX:          idx_r <= '0;
          OP_NEXT, OP_SD_WR, OP_P_ADV:  idx_r <= idx_p1;
          OP_SU_WR:                     idx_r <= idx_m1;
          OP_CNT_DEC:                   cnt_r <= cnt_r - CNT_W'(1);
          OP_INS:                       cnt_r <= cnt_r + CNT_W'(1);
          OP_SU_INIT: begin
            pos_r <= idx_r[CNT_W-1:0];
            idx_r <= IDX_W'(cnt_r);
          end
          default: ;
        endcase
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_user_addr  = out_user_r;
  assign out_used_bytes = out_used_r;
  assign out_free_bytes = out_free_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SEG_DEPTH)) else $error("segment count above table depth");
  a_dead_heap: assert property (@(posedge clk) disable iff (!rst_n)
    !heap_ok_r |-> cnt_r == '0) else $error("segments present on unusable heap");
  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (used_r == '0) && (valid_r == '0)) else $error("config write left state");

endmodule

// File: verif/ffca_checker.sv
// Checker for the first-fit coalescing allocator: watches both channels and the config port.
// Keeps its own allocator state, predicts each result and compares it field by field.
// Depends on ffca_pkg, ffca_in_if and ffca_out_if.
`timescale 1ns / 1ps
module ffca_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  ffca_in_if                            in_ch,
  ffca_out_if                           out_ch,
  input  logic                          cfg_we,
  input  logic [ffca_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [ffca_pkg::ADDR_W-1:0]   cfg_wdata,
  output int                            mismatch_count,
  output int                            results_waiting,
  output int                            results_checked
);
  import ffca_pkg::*;

  typedef struct {
    status_t     st;
    logic [31:0] user;
    logic [31:0] used;
    logic [31:0] avail;
  } alloc_result_t;

  alloc_result_t result_fifo[$];

  logic [31:0] base_addr, heap_len;
  bit          heap_usable;
  logic [63:0] seg_base[SEG_DEPTH];
  logic [63:0] seg_len[SEG_DEPTH];
  int          seg_cnt;
  logic [63:0] rec_user[REC_DEPTH];
  logic [63:0] rec_base[REC_DEPTH];
  logic [63:0] rec_len[REC_DEPTH];
  bit          rec_live[REC_DEPTH];
  logic [63:0] bytes_held;

  function automatic void rebuild_heap();
    logic [63:0] top_end;
    top_end = {32'd0, base_addr} + {32'd0, heap_len};
    foreach (rec_live[i]) rec_live[i] = 0;
    bytes_held  = '0;
    heap_usable = (heap_len >= MIN_FREE_BYTES) && ((top_end - 1) <= 64'hFFFF_FFFF);
    seg_cnt = 0;
    if (heap_usable) begin
      seg_base[0] = base_addr;
      seg_len[0]  = heap_len;
      seg_cnt     = 1;
    end
  endfunction

  function automatic status_t carve_block(logic [63:0] size, logic [4:0] alog,
                                          output logic [63:0] user);
    logic [63:0] align, bs, be, ua, total, rem;
    int slot;
    user  = '0;
    align = 64'd1 << alog;
    if (size == 0) size = 1;
    if (align < (64'd1 << MIN_ALIGN_LOG2)) align = 64'd1 << MIN_ALIGN_LOG2;
    slot = 0;
    while (slot < REC_DEPTH && rec_live[slot]) slot++;
    if (slot == REC_DEPTH) return ST_TABLE_FULL;
    for (int i = 0; i < seg_cnt; i++) begin
      bs    = seg_base[i];
      be    = bs + seg_len[i];
      ua    = (bs + HEADER_BYTES + align - 1) & ~(align - 1);
      total = ua + size - bs;
      if (bs + total > be) continue;
      rem = be - (bs + total);
      if (rem > 0 && rem < MIN_FREE_BYTES) continue;
      if (rem >= MIN_FREE_BYTES) begin
        // tail keeps the segment's slot in the sorted table
        seg_base[i] = bs + total;
        seg_len[i]  = rem;
      end else begin
        for (int k = i; k + 1 < seg_cnt; k++) begin
          seg_base[k] = seg_base[k+1];
          seg_len[k]  = seg_len[k+1];
        end
        seg_cnt--;
      end
      rec_live[slot] = 1;
      rec_user[slot] = ua;
      rec_base[slot] = bs;
      rec_len[slot]  = total;
      bytes_held     = (bytes_held + total) & 64'hFFFF_FFFF;
      user           = ua;
      return ST_OK;
    end
    return ST_EXHAUSTED;
  endfunction

  function automatic status_t release_block(logic [63:0] addr);
    int r, pos;
    logic [63:0] bs, bsz, be;
    bit mprev, mnext;
    r = 0;
    while (r < REC_DEPTH && !(rec_live[r] && rec_user[r] == addr)) r++;
    if (r == REC_DEPTH) return ST_UNKNOWN;
    bs  = rec_base[r];
    bsz = rec_len[r];
    be  = bs + bsz;
    if (bs < base_addr || be > {32'd0, base_addr} + {32'd0, heap_len}) return ST_OOB;
    pos = 0;
    while (pos < seg_cnt && seg_base[pos] < bs) pos++;
    mprev = pos > 0 && (seg_base[pos-1] + seg_len[pos-1] == bs);
    mnext = pos < seg_cnt && seg_base[pos] == be;
    if (mprev && mnext) begin
      seg_len[pos-1] += bsz + seg_len[pos];
      for (int k = pos; k + 1 < seg_cnt; k++) begin
        seg_base[k] = seg_base[k+1];
        seg_len[k]  = seg_len[k+1];
      end
      seg_cnt--;
    end else if (mprev) begin
      seg_len[pos-1] += bsz;
    end else if (mnext) begin
      seg_base[pos] = bs;
      seg_len[pos] += bsz;
    end else begin
      if (seg_cnt >= SEG_DEPTH) return ST_TABLE_FULL;
      for (int k = seg_cnt; k > pos; k--) begin
        seg_base[k] = seg_base[k-1];
        seg_len[k]  = seg_len[k-1];
      end
      seg_base[pos] = bs;
      seg_len[pos]  = bsz;
      seg_cnt++;
    end
    rec_live[r] = 0;
    bytes_held  = (bytes_held - bsz) & 64'hFFFF_FFFF;
    return ST_OK;
  endfunction

  function automatic alloc_result_t predict_request(logic op, logic [31:0] size,
                                                    logic [4:0] alog, logic [31:0] addr);
    alloc_result_t res;
    logic [63:0] ua;
    ua     = '0;
    res.st = ST_OK;
    if (!op) begin
      if (!heap_usable) res.st = ST_UNUSABLE;
      else res.st = carve_block({32'd0, size}, alog, ua);
    end else if (addr != 0) begin
      res.st = heap_usable ? release_block({32'd0, addr}) : ST_UNUSABLE;
    end
    res.user  = ua[31:0];
    res.used  = bytes_held[31:0];
    res.avail = heap_len - bytes_held[31:0];
    return res;
  endfunction

  always @(posedge clk) begin
    alloc_result_t exp_res;
    if (!rst_n) begin
      base_addr = '0;
      heap_len  = '0;
      rebuild_heap();
      result_fifo.delete();
      mismatch_count  <= 0;
      results_checked <= 0;
    end else begin
      // check results first; the oldest expectation always belongs to the oldest transaction
      if (out_ch.valid && out_ch.ready) begin
        if (result_fifo.size() == 0) begin
          $display("%0t: result with no request pending (status %0d)", $time, out_ch.status);
          mismatch_count <= mismatch_count + 1;
        end else begin
          exp_res = result_fifo.pop_front();
          results_checked <= results_checked + 1;
          if (out_ch.status !== exp_res.st || out_ch.user_addr !== exp_res.user ||
              out_ch.used_bytes !== exp_res.used || out_ch.free_bytes !== exp_res.avail) begin
            $display("%0t: mismatch expected st=%0d user=%h used=%h free=%h", $time,
                     exp_res.st, exp_res.user, exp_res.used, exp_res.avail);
            $display("%0t:          actual   st=%0d user=%h used=%h free=%h", $time,
                     out_ch.status, out_ch.user_addr, out_ch.used_bytes, out_ch.free_bytes);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        result_fifo.push_back(predict_request(in_ch.opcode, in_ch.req_size,
                                              in_ch.align_log2, in_ch.free_addr));
      if (cfg_we) begin
        if (cfg_index == REG_HEAP_START) base_addr = cfg_wdata;
        else if (cfg_index == REG_HEAP_SIZE) heap_len = cfg_wdata;
        if (cfg_index == REG_HEAP_START || cfg_index == REG_HEAP_SIZE) rebuild_heap();
      end
    end
    results_waiting <= result_fifo.size();
  end

endmodule

// File: verif/testbench.sv
// Top of the allocator testbench: clock, reset, request stimulus, config writes and verdict.
// Depends on ffca_pkg, the channel interfaces, ffca_checker and the allocator top.
`timescale 1ns / 1ps
module testbench;
  import ffca_pkg::*;

  logic              clk = 0;
  logic              rst_n = 0;
  logic              cfg_we = 0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [ADDR_W-1:0] cfg_wdata = '0;

  ffca_in_if  req_ch();
  ffca_out_if rsp_ch();

  int mismatch_count, results_waiting, results_checked;
  int idle_mode;        // 0 none, 1 sender idles, 2 receiver stalls, 3 both lightly
  bit hold_req;         // ask the receiver for one long hold-off
  int phases_run;
  logic [31:0] live_addrs[$];
  logic [31:0] freed_addrs[$];

  first_fit_coalescing_allocator_top DUT (
    .clk(clk), .rst_n(rst_n), .in_if(req_ch.sink), .out_if(rsp_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  ffca_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(req_ch), .out_ch(rsp_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatch_count(mismatch_count), .results_waiting(results_waiting),
    .results_checked(results_checked)
  );

  always #5 clk = ~clk;

  initial begin
    req_ch.valid = 0;
    req_ch.opcode = 0;
    req_ch.req_size = '0;
    req_ch.align_log2 = '0;
    req_ch.free_addr = '0;
    rsp_ch.ready = 0;
  end

  // Collect addresses handed out so that most frees hit live blocks.
  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid && rsp_ch.ready && rsp_ch.status == ST_OK &&
        rsp_ch.user_addr != 0)
      live_addrs.push_back(rsp_ch.user_addr);
  end

  // Receiver: stall per idle mode; on request hold off for a long count of its own.
  always @(negedge clk) begin
    int hold_left;
    if (hold_req && hold_left == 0) begin
      hold_left = 400;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 0;
    end else if (idle_mode == 2) begin
      rsp_ch.ready <= $urandom_range(99) >= 63;
    end else if (idle_mode == 3) begin
      rsp_ch.ready <= $urandom_range(99) >= 12;
    end else begin
      rsp_ch.ready <= 1;
    end
  end

  // Offer one transaction, idling first as the mode says; return once it is accepted.
  // Ready only moves after a rising edge, so test it at the falling edge before the accept.
  task automatic send_request(logic op, logic [31:0] size, logic [4:0] alog,
                              logic [31:0] addr);
    int gap_pct;
    gap_pct = (idle_mode == 1) ? 63 : (idle_mode == 3) ? 12 : 0;
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      req_ch.valid <= 0;
    end
    @(negedge clk);
    req_ch.valid      <= 1;
    req_ch.opcode     <= op;
    req_ch.req_size   <= size;
    req_ch.align_log2 <= alog;
    req_ch.free_addr  <= addr;
    while (!req_ch.ready) @(negedge clk);
    @(posedge clk);
  endtask

  // Drop valid, wait out every result and the block's tail, then reprogram the heap.
  task automatic program_heap(logic [31:0] start_addr, logic [31:0] len);
    @(negedge clk);
    req_ch.valid <= 0;
    wait (results_waiting == 0);
    repeat (450) @(negedge clk);
    cfg_we <= 1; cfg_index <= REG_HEAP_START; cfg_wdata <= start_addr;
    @(negedge clk);
    cfg_index <= REG_HEAP_SIZE; cfg_wdata <= len;
    @(negedge clk);
    cfg_we <= 0;
    live_addrs.delete();
    freed_addrs.delete();
    phases_run++;
  endtask

  task automatic send_alloc(logic [31:0] size, logic [4:0] alog);
    send_request(1'b0, size, alog, '0);
  endtask

  task automatic send_free(logic [31:0] addr);
    send_request(1'b1, '0, '0, addr);
  endtask

  // Mostly well-formed allocs and live-block frees, with zero, stale and stray addresses mixed in.
  task automatic random_request();
    int pick, idx;
    logic [31:0] size, addr;
    logic [4:0] alog;
    pick = $urandom_range(99);
    if (pick < 55 || live_addrs.size() == 0 && pick < 85) begin
      pick = $urandom_range(99);
      size = (pick < 70) ? $urandom_range(256) : (pick < 92) ? $urandom_range(4096)
                                                             : $urandom;
      alog = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(6));
      send_alloc(size, alog);
    end else begin
      pick = $urandom_range(99);
      if (pick < 70 && live_addrs.size() > 0) begin
        idx  = $urandom_range(live_addrs.size() - 1);
        addr = live_addrs[idx];
        live_addrs.delete(idx);
        freed_addrs.push_back(addr);
      end else if (pick < 80) begin
        addr = '0;
      end else if (pick < 90 && freed_addrs.size() > 0) begin
        addr = freed_addrs[$urandom_range(freed_addrs.size() - 1)];
      end else begin
        addr = $urandom;
      end
      send_free(addr);
    end
  endtask

  initial begin
    logic [31:0] heap_sizes[4] = '{32'd512, 32'd4096, 32'd1024, 32'd65536};
    idle_mode  = 0;
    hold_req   = 0;
    phases_run = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1;

    // After reset the heap is unusable: allocate and nonzero free both say so.
    send_alloc(32'd16, 5'd0);
    send_free(32'h0000_1018);
    send_free(32'd0);

    // Normal heap: zero size, max size, every alignment extreme, frees of all kinds.
    program_heap(32'h0000_1000, 32'h0000_2000);
    send_alloc(32'd0, 5'd0);
    send_alloc(32'd40, 5'd4);
    send_alloc(32'd100, 5'd16);
    send_alloc(32'd8, 5'd31);
    send_alloc(32'hFFFF_FFFF, 5'd3);
    send_free(32'd0);
    send_free(32'hFFFF_FFFF);
    @(negedge clk);
    req_ch.valid <= 0;
    wait (results_waiting == 0);
    while (live_addrs.size() > 0) begin
      freed_addrs.push_back(live_addrs[0]);
      send_free(live_addrs.pop_front());
    end
    send_free(freed_addrs[0]);   // double free

    // Exact-fit and top-of-address-space heap, then all but the top byte of the address space.
    program_heap(32'hFFFF_FFF0, 32'd16);
    send_alloc(32'd1, 5'd0);
    program_heap(32'hFFFF_FFD0, 32'd48);
    send_alloc(32'd24, 5'd0);
    send_alloc(32'd1, 5'd0);
    program_heap(32'h0000_0000, 32'hFFFF_FFFF);
    send_alloc(32'hFFFF_0000, 5'd0);
    // Heap ending exactly at the address-space top (usable), then one byte too small (unusable).
    program_heap(32'h0000_0001, 32'hFFFF_FFFF);
    send_alloc(32'd4, 5'd0);
    program_heap(32'h0000_8000, 32'd15);
    send_alloc(32'd4, 5'd0);
    send_free(32'h0000_8018);

    // Fill the record table on a roomy heap, then free half so segments fragment.
    program_heap(32'h0001_0000, 32'h0010_0000);
    repeat (66) send_alloc(32'd8, 5'd0);
    @(negedge clk);
    req_ch.valid <= 0;
    wait (results_waiting == 0);
    for (int i = 0; i < live_addrs.size(); i += 2) send_free(live_addrs[i]);

    // Random phases across heap sizes and idle modes.
    for (int p = 0; p < 8; p++) begin
      idle_mode = p % 4;
      program_heap(32'($urandom_range(255)) << 8, heap_sizes[p % 4]);
      for (int n = 0; n < 180; n++) begin
        if (p == 1 && n == 40) hold_req = 1;   // long receiver hold-off fills the block
        if (p == 2 && n == 90) begin          // sender pauses until everything is back
          @(negedge clk);
          req_ch.valid <= 0;
          wait (results_waiting == 0);
        end
        random_request();
      end
    end

    @(negedge clk);
    req_ch.valid <= 0;
    wait (results_waiting == 0);
    repeat (450) @(negedge clk);
    $display("Ran %0d heap settings; %0d results checked over alloc/free traffic",
             phases_run, results_checked);
    $display("with idle and stall phases, a long receiver hold-off and a drain pause.");
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Timed out waiting for results");
    $display("status: fail");
    $finish;
  end

endmodule

// File: first_fit_coalescing_allocator_top.f
rtl/ffca_pkg.sv
rtl/ffca_in_if.sv
rtl/ffca_out_if.sv
rtl/ffca_ctrl.sv
rtl/ffca_dp.sv
rtl/first_fit_coalescing_allocator_top.sv
verif/ffca_checker.sv
verif/testbench.sv
